// ===== rtl/gpio_pkg.sv =====
package gpio_pkg;

    localparam int NUM_BANKS        = 2;
    localparam int PINS_PER_BANK    = 32;
    localparam int DEBOUNCE_SAMPLES = 3;

    localparam int DATA_W = 32;
    localparam int PIN_W  = 64;
    localparam int CNT_W  = 2;

    typedef logic [PINS_PER_BANK-1:0] t_pins;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        REG_DATA     = 4'd0,
        REG_DIR      = 4'd1,
        REG_INTEN    = 4'd2,
        REG_MASK     = 4'd3,
        REG_TYPE     = 4'd4,
        REG_POL      = 4'd5,
        REG_DEBOUNCE = 4'd6,
        REG_STATUS   = 4'd7,
        REG_EXTPORT  = 4'd8,
        REG_EOI      = 4'd9
    } t_reg_idx;

    typedef struct packed {
        logic       tick;
        logic       wr;
        logic [3:0] idx;
        t_pins      wdata;
        t_pins      pins;
    } t_bank_req;

    typedef struct packed {
        t_pins rdata;
        t_pins out_level;
        t_pins drive_dir;
        logic  irq;
    } t_bank_view;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [PIN_W-1:0]  pins_out;
        logic [PIN_W-1:0]  pins_drive_enable;
        logic              irq;
        logic              access_error;
    } t_result;

endpackage

// ===== rtl/gpio_bank.sv =====
module gpio_bank
    import gpio_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bank_req  i_req,
    output t_bank_view o_view
);

    localparam logic [CNT_W-1:0] DB_LIMIT = CNT_W'(DEBOUNCE_SAMPLES);

    t_pins r_out, r_dir, r_ien, r_mask, r_type, r_pol, r_deb, r_edge, r_filt;
    t_pins n_out, n_dir, n_ien, n_mask, n_type, n_pol, n_deb, n_edge, n_filt;
    logic [CNT_W-1:0] r_cnt [PINS_PER_BANK];
    logic [CNT_W-1:0] n_cnt [PINS_PER_BANK];

    function automatic t_pins masked_status(t_pins ien, t_pins dir, t_pins typ,
                                            t_pins filt, t_pins pol, t_pins edg,
                                            t_pins msk);
        t_pins lvl;
        lvl = ~typ & ~(filt ^ pol);
        return (lvl | (typ & edg)) & ien & ~dir & ~msk;
    endfunction

    always_comb begin
        logic [CNT_W-1:0] cnt_inc;
        t_pins            hit;
        n_out  = r_out;
        n_dir  = r_dir;
        n_ien  = r_ien;
        n_mask = r_mask;
        n_type = r_type;
        n_pol  = r_pol;
        n_deb  = r_deb;
        n_edge = r_edge;
        n_filt = r_filt;
        n_cnt  = r_cnt;
        cnt_inc = '0;
        hit     = '0;
        if (i_req.tick) begin
            // per pin debounce: adopt the sample at once, or after enough disagreeing ticks
            for (int i = 0; i < PINS_PER_BANK; i++) begin
                cnt_inc = r_cnt[i] + CNT_W'(1);
                if (!r_deb[i] || (i_req.pins[i] == r_filt[i])) begin
                    n_cnt[i]  = '0;
                    n_filt[i] = i_req.pins[i];
                end else if (cnt_inc >= DB_LIMIT) begin
                    n_cnt[i]  = '0;
                    n_filt[i] = i_req.pins[i];
                end else begin
                    n_cnt[i]  = cnt_inc;
                end
            end
            hit    = (r_pol & n_filt & ~r_filt) | (~r_pol & r_filt & ~n_filt);
            n_edge = r_edge | (hit & r_type & r_ien & ~r_dir);
        end else if (i_req.wr) begin
            case (t_reg_idx'(i_req.idx))
                REG_DATA:     n_out  = i_req.wdata;
                REG_DIR:      n_dir  = i_req.wdata;
                REG_INTEN: begin
                    n_ien  = i_req.wdata;
                    n_edge = r_edge & i_req.wdata;
                end
                REG_MASK:     n_mask = i_req.wdata;
                REG_TYPE:     n_type = i_req.wdata;
                REG_POL:      n_pol  = i_req.wdata;
                REG_DEBOUNCE: n_deb  = i_req.wdata;
                REG_EOI:      n_edge = r_edge & ~i_req.wdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(i_req.idx))
            REG_DATA:     o_view.rdata = r_out;
            REG_DIR:      o_view.rdata = r_dir;
            REG_INTEN:    o_view.rdata = r_ien;
            REG_MASK:     o_view.rdata = r_mask;
            REG_TYPE:     o_view.rdata = r_type;
            REG_POL:      o_view.rdata = r_pol;
            REG_DEBOUNCE: o_view.rdata = r_deb;
            REG_STATUS:   o_view.rdata = masked_status(r_ien, r_dir, r_type, r_filt,
                                                       r_pol, r_edge, r_mask);
            REG_EXTPORT:  o_view.rdata = r_filt;
            default:      o_view.rdata = '0;
        endcase
        o_view.out_level = n_out;
        o_view.drive_dir = n_dir;
        o_view.irq       = |masked_status(n_ien, n_dir, n_type, n_filt,
                                          n_pol, n_edge, n_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out  <= '0;
            r_dir  <= '0;
            r_ien  <= '0;
            r_mask <= '0;
            r_type <= '0;
            r_pol  <= '0;
            r_deb  <= '0;
            r_edge <= '0;
            r_filt <= '0;
            for (int i = 0; i < PINS_PER_BANK; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_out  <= n_out;
            r_dir  <= n_dir;
            r_ien  <= n_ien;
            r_mask <= n_mask;
            r_type <= n_type;
            r_pol  <= n_pol;
            r_deb  <= n_deb;
            r_edge <= n_edge;
            r_filt <= n_filt;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/gpio_obuf.sv =====
module gpio_obuf
    import gpio_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;

    // skid entry takes a result while the head waits; space only when it is free
    assign o_space = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || i_ready) begin
            r_main_v <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || i_ready) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== rtl/gpio_controller_with_interrupts.sv =====
// Two-bank GPIO controller with level and edge interrupts, 32 pins per bank.
//
// Request channel (i_valid / o_ready): i_command selects a pin sample tick,
// a register read or a register write; i_bank and i_reg_index address the
// register, i_write_data carries write data and i_pins_in the pin levels of
// a tick (pin i of bank b on bit b*32+i).
// Result channel (o_valid / i_ready): exactly one result per request with the
// read data, the driven levels and drive enables of all pins, irq (OR of the
// masked interrupt status after the request) and access_error.
//
// The controller registers update and the result is captured on the edge
// that accepts the request. While o_ready is high, one request per cycle is
// sustained; the bank register update and a two-entry result buffer set that.
// When the receiver stalls, the buffer holds up to two results and o_ready
// drops only once both entries are full; nothing is lost or repeated.
// Reset (synchronous, active low) clears every register to zero: all pins are
// inputs, level sensitive, active low, interrupts disabled, buffer empty.
module gpio_controller_with_interrupts
    import gpio_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_command,
    input  logic                    i_bank,
    input  logic [3:0]              i_reg_index,
    input  logic [DATA_W-1:0]       i_write_data,
    input  logic [PIN_W-1:0]        i_pins_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [DATA_W-1:0]       o_read_data,
    output logic [PIN_W-1:0]        o_pins_out,
    output logic [PIN_W-1:0]        o_pins_drive_enable,
    output logic                    o_irq,
    output logic                    o_access_error
);

    logic       w_accept;
    logic       w_tick, w_read, w_write;
    logic       w_bank_ok;
    logic       w_err;
    t_pins      w_bank_pins [NUM_BANKS];
    t_bank_req  w_req       [NUM_BANKS];
    t_bank_view w_view      [NUM_BANKS];
    logic [DATA_W-1:0] w_rdata;
    logic [PIN_W-1:0]  w_pins_out;
    logic [PIN_W-1:0]  w_pins_de;
    logic              w_irq;
    t_result    w_res;
    t_result    w_out;

    assign w_accept  = i_valid && o_ready;
    assign w_tick    = (i_command == CMD_TICK);
    assign w_read    = (i_command == CMD_READ);
    assign w_write   = (i_command == CMD_WRITE);
    assign w_bank_ok = (32'(i_bank) < 32'(NUM_BANKS));

    // decode the access: ticks never fail, reserved command and bad index do
    always_comb begin
        if (w_tick) begin
            w_err = 1'b0;
        end else if (!(w_read || w_write) || !w_bank_ok) begin
            w_err = 1'b1;
        end else begin
            case (t_reg_idx'(i_reg_index))
                REG_DATA, REG_DIR, REG_INTEN, REG_MASK,
                REG_TYPE, REG_POL, REG_DEBOUNCE:  w_err = 1'b0;
                REG_STATUS, REG_EXTPORT:          w_err = w_write;
                REG_EOI:                          w_err = w_read;
                default:                          w_err = 1'b1;
            endcase
        end
    end

    // split the sampled pins per bank; pins beyond the 64-bit port read low
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        for (genvar i = 0; i < PINS_PER_BANK; i++) begin : g_pin
            if (b * PINS_PER_BANK + i < PIN_W) begin : g_map
                assign w_bank_pins[b][i]               = i_pins_in[b*PINS_PER_BANK+i];
                assign w_pins_out[b*PINS_PER_BANK+i]   = w_view[b].out_level[i];
                assign w_pins_de[b*PINS_PER_BANK+i]    = w_view[b].drive_dir[i];
            end else begin : g_none
                assign w_bank_pins[b][i] = 1'b0;
            end
        end

        assign w_req[b].tick  = w_accept && w_tick;
        assign w_req[b].wr    = w_accept && w_write && !w_err && (32'(i_bank) == b);
        assign w_req[b].idx   = i_reg_index;
        assign w_req[b].wdata = i_write_data[PINS_PER_BANK-1:0];
        assign w_req[b].pins  = w_bank_pins[b];

        gpio_bank u_bank (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (w_req[b]),
            .o_view  (w_view[b])
        );
    end

    // tie off port bits that no bank reaches
    if (NUM_BANKS * PINS_PER_BANK < PIN_W) begin : g_pad
        assign w_pins_out[PIN_W-1:NUM_BANKS*PINS_PER_BANK] = '0;
        assign w_pins_de[PIN_W-1:NUM_BANKS*PINS_PER_BANK]  = '0;
    end

    // read data of the addressed bank, zero for ticks, writes and errors; irq ORs all banks
    always_comb begin
        w_rdata = '0;
        w_irq   = 1'b0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (w_read && !w_err && (32'(i_bank) == b)) begin
                w_rdata = DATA_W'(w_view[b].rdata);
            end
            w_irq = w_irq | w_view[b].irq;
        end
    end

    assign w_res = '{read_data:         w_rdata,
                     pins_out:          w_pins_out,
                     pins_drive_enable: w_pins_de,
                     irq:               w_irq,
                     access_error:      w_err};

    gpio_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_res),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_read_data         = w_out.read_data;
    assign o_pins_out          = w_out.pins_out;
    assign o_pins_drive_enable = w_out.pins_drive_enable;
    assign o_irq               = w_out.irq;
    assign o_access_error      = w_out.access_error;

endmodule

// ===== rtl/gpio_chk.sv =====
module gpio_chk
    import gpio_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [DATA_W-1:0] o_read_data,
    input logic              o_access_error
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data))
        else $error("result changed while stalled");

    // a failed access never returns data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_access_error |-> o_read_data == '0)
        else $error("read data on access error");

    // reset empties the result buffer
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("buffer not empty after reset");

    // no result appears without a request
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && o_ready) && !o_valid |=> !o_valid)
        else $error("result without request");

endmodule

bind gpio_controller_with_interrupts gpio_chk u_gpio_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_read_data    (o_read_data),
    .o_access_error (o_access_error)
);

// ===== sim/gpio_controller_with_interrupts_tb.sv =====
module gpio_controller_with_interrupts_tb;
    import gpio_pkg::*;

    // Codes the package leaves out: the spare command and the top register index.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [3:0] REG_LAST   = 4'hF;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_FROM    = 300;   // random requests with no idling on either side
    localparam int CALM_TO      = 600;
    localparam int HOLD_AT      = 900;   // accepted requests before the long receiver stall
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 1000;  // cycles with nothing accepted before giving up
    localparam int DRAIN_CYCLES = 4;

    localparam t_result IDLE_VIEW = '0;
    localparam t_result ERR_VIEW  = '{read_data: '0, pins_out: '0, pins_drive_enable: '0,
                                      irq: 1'b0, access_error: 1'b1};

    typedef struct {
        logic [1:0]        cmd;
        logic              bank;
        logic [3:0]        idx;
        logic [DATA_W-1:0] wdata;
        logic [PIN_W-1:0]  pins;
        bit                typed;   // use the hand-written response below
        t_result           want;
    } t_request;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic [1:0]        i_command    = CMD_TICK;
    logic              i_bank       = 1'b0;
    logic [3:0]        i_reg_index  = REG_DATA;
    logic [DATA_W-1:0] i_write_data = '0;
    logic [PIN_W-1:0]  i_pins_in    = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic [PIN_W-1:0]  o_pins_out;
    logic [PIN_W-1:0]  o_pins_drive_enable;
    logic              o_irq;
    logic              o_access_error;

    gpio_controller_with_interrupts dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_command           (i_command),
        .i_bank              (i_bank),
        .i_reg_index         (i_reg_index),
        .i_write_data        (i_write_data),
        .i_pins_in           (i_pins_in),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_read_data         (o_read_data),
        .o_pins_out          (o_pins_out),
        .o_pins_drive_enable (o_pins_drive_enable),
        .o_irq               (o_irq),
        .o_access_error      (o_access_error)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the controller registers, one word per bank.
    // ------------------------------------------------------------------
    t_pins            lvl_out   [NUM_BANKS] = '{default: '0};
    t_pins            dir_out   [NUM_BANKS] = '{default: '0};
    t_pins            int_en    [NUM_BANKS] = '{default: '0};
    t_pins            int_mask  [NUM_BANKS] = '{default: '0};
    t_pins            edge_sel  [NUM_BANKS] = '{default: '0};
    t_pins            pol_high  [NUM_BANKS] = '{default: '0};
    t_pins            deb_en    [NUM_BANKS] = '{default: '0};
    t_pins            edge_seen [NUM_BANKS] = '{default: '0};
    t_pins            pin_level [NUM_BANKS] = '{default: '0};
    logic [CNT_W-1:0] settle_cnt [NUM_BANKS*PINS_PER_BANK] = '{default: '0};

    t_request          directed_rows[$];
    t_request          requests_in_flight[$];  // driven, not yet accepted
    t_result           responses_due[$];
    logic [PIN_W-1:0]  pin_drift   = '0;       // slowly changing pin pattern for ticks
    bit                calm        = 1'b0;
    bit                held_off    = 1'b0;
    int                hold_left   = 0;
    int                n_requests  = 0;
    int                n_mismatch  = 0;
    int                quiet_cycles = 0;

    // Masked interrupt status of one bank: level on level pins, latched edge on edge pins,
    // only for enabled inputs that are not masked.
    function automatic t_pins pending_irqs(int b);
        return ((~edge_sel[b] & ~(pin_level[b] ^ pol_high[b])) | (edge_sel[b] & edge_seen[b]))
               & int_en[b] & ~dir_out[b] & ~int_mask[b];
    endfunction

    // Sample tick: debounce each pin, then latch edges of the right polarity.
    function automatic void sample_pins(logic [PIN_W-1:0] pins);
        t_pins old_lvl;
        t_pins new_lvl;
        t_pins rise;
        t_pins fall;
        int    pos;
        for (int b = 0; b < NUM_BANKS; b++) begin
            old_lvl = pin_level[b];
            new_lvl = old_lvl;
            for (int i = 0; i < PINS_PER_BANK; i++) begin
                pos = b * PINS_PER_BANK + i;
                if (!deb_en[b][i] || pins[pos] == old_lvl[i]) begin
                    settle_cnt[pos] = '0;
                    new_lvl[i] = pins[pos];
                end else begin
                    settle_cnt[pos] = settle_cnt[pos] + 1'b1;
                    if (settle_cnt[pos] >= DEBOUNCE_SAMPLES) begin
                        settle_cnt[pos] = '0;
                        new_lvl[i] = pins[pos];
                    end
                end
            end
            pin_level[b] = new_lvl;
            rise = new_lvl & ~old_lvl;
            fall = old_lvl & ~new_lvl;
            edge_seen[b] |= ((pol_high[b] & rise) | (~pol_high[b] & fall))
                            & edge_sel[b] & int_en[b] & ~dir_out[b];
        end
    endfunction

    // Apply one request to the shadow registers and return the response it gives.
    function automatic t_result gpio_response(logic [1:0] cmd, logic bank, logic [3:0] idx,
                                              t_pins wd, logic [PIN_W-1:0] pins);
        t_result r;
        t_pins   any;
        r = '0;
        case (cmd)
            CMD_TICK: sample_pins(pins);
            CMD_READ: begin
                case (idx)
                    REG_DATA:     r.read_data = lvl_out[bank];
                    REG_DIR:      r.read_data = dir_out[bank];
                    REG_INTEN:    r.read_data = int_en[bank];
                    REG_MASK:     r.read_data = int_mask[bank];
                    REG_TYPE:     r.read_data = edge_sel[bank];
                    REG_POL:      r.read_data = pol_high[bank];
                    REG_DEBOUNCE: r.read_data = deb_en[bank];
                    REG_STATUS:   r.read_data = pending_irqs(bank);
                    REG_EXTPORT:  r.read_data = pin_level[bank];
                    default:      r.access_error = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                case (idx)
                    REG_DATA:     lvl_out[bank] = wd;
                    REG_DIR:      dir_out[bank] = wd;
                    REG_INTEN: begin
                        int_en[bank] = wd;
                        edge_seen[bank] &= wd;
                    end
                    REG_MASK:     int_mask[bank] = wd;
                    REG_TYPE:     edge_sel[bank] = wd;
                    REG_POL:      pol_high[bank] = wd;
                    REG_DEBOUNCE: deb_en[bank] = wd;
                    REG_EOI:      edge_seen[bank] &= ~wd;
                    default:      r.access_error = 1'b1;
                endcase
            end
            default: r.access_error = 1'b1;
        endcase
        any = '0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            any |= pending_irqs(b);
            r.pins_out[b*PINS_PER_BANK +: PINS_PER_BANK]          = lvl_out[b];
            r.pins_drive_enable[b*PINS_PER_BANK +: PINS_PER_BANK] = dir_out[b];
        end
        r.irq = |any;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_row(logic [1:0] cmd, logic bank, logic [3:0] idx,
                                    logic [DATA_W-1:0] wdata, logic [PIN_W-1:0] pins,
                                    bit typed = 1'b0, t_result want = '0);
        t_request rq;
        rq = '{cmd: cmd, bank: bank, idx: idx, wdata: wdata, pins: pins,
               typed: typed, want: want};
        directed_rows.push_back(rq);
    endfunction

    // Favour all-zero, all-one and single-pin words beside plain random data.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(DATA_W - 1);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int       roll;
        rq = '{default: '0};
        roll = $urandom_range(99);
        rq.bank  = 1'($urandom_range(1));
        rq.wdata = pick_word();
        rq.pins  = {$urandom(), $urandom()};
        if (roll < 45) begin
            // Hold most pins steady so the debounce counters get to settle.
            case ($urandom_range(9))
                0:       pin_drift = {$urandom(), $urandom()};
                1, 2:    pin_drift ^= 64'h1 << $urandom_range(PIN_W - 1);
                3:       pin_drift ^= {$urandom(), $urandom()} & {$urandom(), $urandom()};
                default: ;
            endcase
            rq.cmd  = CMD_TICK;
            rq.pins = pin_drift;
            rq.idx  = 4'($urandom_range(REG_LAST));
        end else if (roll < 75) begin
            rq.cmd = CMD_WRITE;
            rq.idx = 4'($urandom_range(REG_DATA, REG_EOI));
            if (rq.idx == REG_STATUS || rq.idx == REG_EXTPORT)
                rq.idx = REG_EOI;
        end else if (roll < 95) begin
            rq.cmd = CMD_READ;
            rq.idx = 4'($urandom_range(REG_DATA, REG_EXTPORT));
        end else begin
            case ($urandom_range(3))
                0: begin
                    rq.cmd = CMD_UNUSED;
                    rq.idx = 4'($urandom_range(REG_LAST));
                end
                1: begin
                    rq.cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
                    rq.idx = 4'($urandom_range(REG_EOI + 1, REG_LAST));
                end
                2: begin
                    rq.cmd = CMD_WRITE;
                    rq.idx = $urandom_range(1) ? REG_STATUS : REG_EXTPORT;
                end
                default: begin
                    rq.cmd = CMD_READ;
                    rq.idx = REG_EOI;
                end
            endcase
        end
        return rq;
    endfunction

    // Offer one request and hold it until accepted; sometimes drop valid for a cycle first.
    task automatic offer(input t_request rq);
        if (!calm && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        requests_in_flight.push_back(rq);
        i_valid      <= 1'b1;
        i_command    <= rq.cmd;
        i_bank       <= rq.bank;
        i_reg_index  <= rq.idx;
        i_write_data <= rq.wdata;
        i_pins_in    <= rq.pins;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= 40)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, none during the calm stretch, and one long hold-off
    // that lets the result buffer fill so that o_ready drops.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!held_off && n_requests >= HOLD_AT) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Work out the response of each accepted request, in order.
    always @(posedge i_clk) begin
        t_request rq;
        t_result  want;
        if (i_rst_n && i_valid && o_ready) begin
            rq   = requests_in_flight.pop_front();
            want = gpio_response(i_command, i_bank, i_reg_index, i_write_data, i_pins_in);
            if (rq.typed)
                want = rq.want;
            responses_due.push_back(want);
            n_requests++;
        end
    end

    // Compare each accepted response with the oldest one due.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (responses_due.size() == 0) begin
                report_mismatch($sformatf("response with nothing due, read_data %h", o_read_data));
            end else begin
                want = responses_due.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              o_read_data, want.read_data));
                if (o_pins_out !== want.pins_out)
                    report_mismatch($sformatf("pins_out %h, want %h",
                                              o_pins_out, want.pins_out));
                if (o_pins_drive_enable !== want.pins_drive_enable)
                    report_mismatch($sformatf("pins_drive_enable %h, want %h",
                                              o_pins_drive_enable, want.pins_drive_enable));
                if (o_irq !== want.irq)
                    report_mismatch($sformatf("irq %b, want %b", o_irq, want.irq));
                if (o_access_error !== want.access_error)
                    report_mismatch($sformatf("access_error %b, want %b",
                                              o_access_error, want.access_error));
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_request rq;

        // Straight out of reset: reads give zero and every bad access flags an error.
        add_row(CMD_READ,   1'b0, REG_DATA,     '0, '0, 1'b1, IDLE_VIEW);
        add_row(CMD_READ,   1'b1, REG_STATUS,   '0, '0, 1'b1, IDLE_VIEW);
        add_row(CMD_WRITE,  1'b0, REG_STATUS,   '1, '0, 1'b1, ERR_VIEW);
        add_row(CMD_WRITE,  1'b1, REG_EXTPORT,  '1, '0, 1'b1, ERR_VIEW);
        add_row(CMD_READ,   1'b0, REG_EOI,      '0, '0, 1'b1, ERR_VIEW);
        add_row(CMD_READ,   1'b1, REG_LAST,     '0, '0, 1'b1, ERR_VIEW);
        add_row(CMD_UNUSED, 1'b1, REG_DATA,     '1, '1, 1'b1, ERR_VIEW);
        // Outputs and directions at their extremes.
        add_row(CMD_WRITE,  1'b0, REG_DATA,     '1, '0);
        add_row(CMD_WRITE,  1'b1, REG_DATA,     32'h8000_0001, '0);
        add_row(CMD_WRITE,  1'b0, REG_DIR,      32'hFFFF_0000, '0);
        // Level interrupts on bank 0, active low with pins at zero: status fires.
        add_row(CMD_WRITE,  1'b0, REG_INTEN,    '1, '0);
        add_row(CMD_READ,   1'b0, REG_STATUS,   '0, '0);
        add_row(CMD_WRITE,  1'b0, REG_MASK,     32'h0000_00FF, '0);
        // Edge interrupts on bank 1 with mixed polarity and half the pins debounced.
        add_row(CMD_WRITE,  1'b1, REG_INTEN,    '1, '0);
        add_row(CMD_WRITE,  1'b1, REG_TYPE,     '1, '0);
        add_row(CMD_WRITE,  1'b1, REG_POL,      32'h5555_5555, '0);
        add_row(CMD_WRITE,  1'b1, REG_DEBOUNCE, 32'hFFFF_0000, '0);
        add_row(CMD_TICK,   1'b0, REG_DATA,     '0, '1);
        add_row(CMD_TICK,   1'b0, REG_DATA,     '0, '1);
        add_row(CMD_TICK,   1'b0, REG_DATA,     '0, '1);
        add_row(CMD_READ,   1'b1, REG_EXTPORT,  '0, '0);
        add_row(CMD_TICK,   1'b0, REG_DATA,     '0, '0);
        add_row(CMD_READ,   1'b1, REG_STATUS,   '0, '0);
        // Clear half the latched edges, then drop enables, which clears theirs too.
        add_row(CMD_WRITE,  1'b1, REG_EOI,      32'h0000_FFFF, '0);
        add_row(CMD_WRITE,  1'b1, REG_INTEN,    32'h00FF_00FF, '0);
        add_row(CMD_READ,   1'b1, REG_STATUS,   '0, '0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer(directed_rows[k]);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            calm = (k >= CALM_FROM && k < CALM_TO);
            rq = random_request();
            offer(rq);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Drain what is still due, then idle for DRAIN_CYCLES before reporting.
        while (requests_in_flight.size() != 0 || responses_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
